@@ design/sm4_pkg.sv @@
// sm4_pkg: shared types, constants and round functions for the sm4 block cipher core
// depends on nothing; imported by sm4_key_sched, sm4_round and sm4_block_cipher_core
`timescale 1ns / 1ps

package sm4_pkg;

   // number of cipher rounds and width of a round index
   localparam int ROUNDS   = 32;
   localparam int RK_IDX_W = $clog2(ROUNDS);

   // configuration port geometry: two 64-bit registers at byte addresses 0 and 8
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // register index codes, taken from address bit 3
   localparam logic REG_KEY_HIGH = 1'b0;
   localparam logic REG_KEY_LOW  = 1'b1;

   // operation codes of the func field
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   // system parameter fk
   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   // sm4 substitution box
   localparam logic [7:0] SBOX_TAB [0:255] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
      8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
      8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
      8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
      8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
      8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
      8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
      8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
      8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
      8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
      8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
      8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
      8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
      8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
      8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
      8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
      8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
      8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
      8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
      8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
      8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
      8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
   };

   // all round keys, entry i used by round i of an encryption
   typedef logic [ROUNDS-1:0][31:0] rk_words_type;

   // control bits that travel with a block through the round pipeline
   typedef struct packed {
      logic valid;
      logic func;
   } stage_ctrl_type;

   // key schedule status seen by the top level
   typedef struct packed {
      logic pending;   // key written, expansion about to start
      logic busy;      // expansion rounds in progress
   } ks_status_type;

   // non-linear transform: four parallel s-box lookups
   function automatic logic [31:0] tau(input logic [31:0] v);
      tau = {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
   endfunction

   // linear transform of the data rounds: rotations 2, 10, 18 and 24
   function automatic logic [31:0] lin_data(input logic [31:0] b);
      lin_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                   ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // linear transform of the key schedule: rotations 13 and 23
   function automatic logic [31:0] lin_key(input logic [31:0] b);
      lin_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // round constant ck: byte j of word i is (4*i + j) * 7 mod 256, first byte high
   function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] i);
      logic [31:0] w;
      logic [7:0]  idx;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         idx = 8'({i, 2'(j)});
         w   = {w[23:0], 8'(idx * 8'd7)};
      end
      ck_word = w;
   endfunction

endpackage

@@ design/sm4_block_cipher_core.sv @@
// sm4_block_cipher_core: top level of the sm4 cipher, key schedule plus round pipeline
// depends on sm4_pkg, sm4_key_sched and sm4_round
`timescale 1ns / 1ps

// The core encrypts or decrypts one 128-bit block per clock cycle (ECB, func 0 encrypt,
// 1 decrypt) through a pipeline of 32 registered rounds, one round per stage, and the last
// round register is the output register. When the output is stalled the whole pipeline
// holds and requests are stalled. The 128-bit key sits in two 64-bit registers (key_high at
// address 0, key_low at 8). After reset and after every key write the key schedule runs
// (a load step, then one round key per cycle in a single shared round unit), and requests
// are stalled until it has finished. Write keys only while no blocks are in flight.

module sm4_block_cipher_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [63:0]                    req_data_high,
   input  logic [63:0]                    req_data_low,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [63:0]                    rsp_out_high,
   output logic [63:0]                    rsp_out_low,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sm4_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sm4_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sm4_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   import sm4_pkg::*;

   rk_words_type   rk_words;
   ks_status_type  ks_status;
   logic           advance;
   logic           ks_idle;
   stage_ctrl_type stage_ctrl [0:ROUNDS];
   logic [127:0]   stage_data [0:ROUNDS];
   logic [ROUNDS:1] stage_valid;

   // key registers and key expansion
   sm4_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .rk_words   (rk_words),
      .status     (ks_status)
   );

   // pipeline moves whenever the output register is empty or being taken
   assign ks_idle   = ~ks_status.pending & ~ks_status.busy;
   assign advance   = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~ks_idle | ~advance;

   // request enters stage zero
   assign stage_ctrl[0].valid = req_valid & ks_idle;
   assign stage_ctrl[0].func  = req_func;
   assign stage_data[0]       = {req_data_high, req_data_low};

   // round pipeline
   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      sm4_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_ctrl (stage_ctrl[i]),
         .prev_data (stage_data[i]),
         .rk_enc    (rk_words[i]),
         .rk_dec    (rk_words[ROUNDS-1-i]),
         .ctrl      (stage_ctrl[i+1]),
         .data      (stage_data[i+1])
      );
      assign stage_valid[i+1] = stage_ctrl[i+1].valid;
   end

   // final word reversal
   assign rsp_valid    = stage_ctrl[ROUNDS].valid;
   assign rsp_out_high = {stage_data[ROUNDS][31:0], stage_data[ROUNDS][63:32]};
   assign rsp_out_low  = {stage_data[ROUNDS][95:64], stage_data[ROUNDS][127:96]};

   // round keys only change while the schedule is running
   a_keys_stable_when_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(ks_status.busy) |-> $stable(rk_words))
      else $error("round keys changed outside key expansion");

   // a stalled result freezes every stage
   a_pipe_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(stage_valid))
      else $error("pipeline moved while the result was stalled");

   // a key write blocks requests until the schedule has rerun
   a_stall_after_key_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) |=> req_stall)
      else $error("request not stalled after key write");

endmodule

@@ design/sm4_key_sched.sv @@
// sm4_key_sched: key registers behind the configuration port and the iterative key expansion
// depends on sm4_pkg (constants, tau, lin_key, ck_word, status and round key types)
`timescale 1ns / 1ps

module sm4_key_sched (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sm4_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sm4_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sm4_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output sm4_pkg::rk_words_type              rk_words,
   output sm4_pkg::ks_status_type             status
);

   import sm4_pkg::*;

   logic [CSR_DATA_W-1:0] key_high_ff, key_high_in;
   logic [CSR_DATA_W-1:0] key_low_ff, key_low_in;
   logic                  pending_ff, pending_in;
   logic                  busy_ff, busy_in;
   logic [RK_IDX_W-1:0]   cnt_ff, cnt_in;
   logic [3:0][31:0]      k_ff, k_in;
   rk_words_type          rk_ff, rk_in;
   logic                  wr_en;
   logic [31:0]           mix;
   logic [31:0]           new_key;

   // register write decode, index from address bit 3
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (wr_en) begin
         case (paddr[3])
            REG_KEY_HIGH: key_high_in = pwdata;
            REG_KEY_LOW:  key_low_in  = pwdata;
            default:      key_high_in = key_high_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (paddr[3])
         REG_KEY_HIGH: prdata = key_high_ff;
         REG_KEY_LOW:  prdata = key_low_ff;
         default:      prdata = '0;
      endcase
   end

   // one key expansion round
   always_comb begin
      mix     = k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ ck_word(cnt_ff);
      new_key = k_ff[0] ^ lin_key(tau(mix));
   end

   // expansion sequencing: a write restarts it, one round key per cycle
   always_comb begin
      pending_in = pending_ff;
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      k_in       = k_ff;
      rk_in      = rk_ff;
      if (pending_ff) begin
         pending_in = 1'b0;
         busy_in    = 1'b1;
         cnt_in     = '0;
         k_in[0]    = key_high_ff[63:32] ^ FK0;
         k_in[1]    = key_high_ff[31:0]  ^ FK1;
         k_in[2]    = key_low_ff[63:32]  ^ FK2;
         k_in[3]    = key_low_ff[31:0]   ^ FK3;
      end else if (busy_ff) begin
         rk_in[cnt_ff] = new_key;
         k_in          = {new_key, k_ff[3], k_ff[2], k_ff[1]};
         cnt_in        = cnt_ff + 1'b1;
         busy_in       = (cnt_ff != RK_IDX_W'(ROUNDS - 1));
      end
      if (wr_en) begin
         pending_in = 1'b1;
         busy_in    = 1'b0;
      end
   end

   // control, key and round key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         pending_ff  <= 1'b1;
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         rk_ff       <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         pending_ff  <= pending_in;
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         rk_ff       <= rk_in;
      end
   end

   // expansion working words
   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   assign rk_words       = rk_ff;
   assign status.pending = pending_ff;
   assign status.busy    = busy_ff;

endmodule

@@ design/sm4_round.sv @@
// sm4_round: one registered sm4 round of the block pipeline, key picked by operation
// depends on sm4_pkg (tau, lin_data, stage control type)
`timescale 1ns / 1ps

module sm4_round (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  sm4_pkg::stage_ctrl_type prev_ctrl,
   input  logic [127:0]            prev_data,
   input  logic [31:0]             rk_enc,
   input  logic [31:0]             rk_dec,
   output sm4_pkg::stage_ctrl_type ctrl,
   output logic [127:0]            data
);

   import sm4_pkg::*;

   stage_ctrl_type ctrl_ff, ctrl_in;
   logic [127:0]   data_ff, data_in;
   logic [31:0]    rk;
   logic [31:0]    nx;

   // round function on words x0..x3, x0 in the top bits
   always_comb begin
      rk      = (prev_ctrl.func == FUNC_DECRYPT) ? rk_dec : rk_enc;
      nx      = prev_data[127:96]
                ^ lin_data(tau(prev_data[95:64] ^ prev_data[63:32] ^ prev_data[31:0] ^ rk));
      data_in = {prev_data[95:0], nx};
      ctrl_in = prev_ctrl;
   end

   // valid and operation bit
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // block words
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign ctrl = ctrl_ff;
   assign data = data_ff;

endmodule
